/* rtl/itp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// itp_pkg
// Shared types, character codes and helpers for the infix to postfix block.
// ============================================================================
package itp_pkg;

    // Default operator stack depth
    localparam int STACK_DEPTH_DEF = 8;

    // ASCII operator characters
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // Stored operator codes (2 bits in the stack memory)
    typedef logic [1:0] op_code_t;
    localparam op_code_t OP_ADD = 2'd0;
    localparam op_code_t OP_SUB = 2'd1;
    localparam op_code_t OP_MUL = 2'd2;
    localparam op_code_t OP_DIV = 2'd3;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHAR,
        ST_TOP,
        ST_NEXT,
        ST_RD
    } state_t;

    // True for + - * /
    function automatic logic is_operator(input logic [7:0] sym);
        logic hit;
        begin
            case (sym)
                CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: hit = 1'b1;
                default: hit = 1'b0;
            endcase
            return hit;
        end
    endfunction

    // Character to stored code; meaningful only for operators
    function automatic op_code_t op_encode(input logic [7:0] sym);
        op_code_t code;
        begin
            case (sym)
                CH_MINUS: code = OP_SUB;
                CH_STAR:  code = OP_MUL;
                CH_SLASH: code = OP_DIV;
                default:  code = OP_ADD;
            endcase
            return code;
        end
    endfunction

    // Stored code back to its character
    function automatic logic [7:0] op_char(input op_code_t code);
        logic [7:0] ch;
        begin
            case (code)
                OP_ADD:  ch = CH_PLUS;
                OP_SUB:  ch = CH_MINUS;
                OP_MUL:  ch = CH_STAR;
                default: ch = CH_SLASH;
            endcase
            return ch;
        end
    endfunction

    // High precedence class: * and /
    function automatic logic prec_high(input op_code_t code);
        return (code == OP_MUL) || (code == OP_DIV);
    endfunction

    // Stacked operator pops before a new one: top precedence >= new precedence
    function automatic logic pops_before(input op_code_t top, input op_code_t cur);
        return prec_high(top) || !prec_high(cur);
    endfunction

endpackage
`default_nettype wire

/* rtl/infix_to_postfix_converter_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// infix_to_postfix_converter_top
// Shunting-yard converter without parentheses; operator stack in a RAM.
// ============================================================================
//
//  Channel   Dir  Beat contents
//  s_axis    in   tdata[7:0] symbol, tlast expr_end
//  m_axis    out  tdata[7:0] out_symbol, tlast run_last,
//                 tuser[0] expr_done, tuser[1] overflow
//
//  A character is taken in ST_IDLE and emitted in ST_CHAR; an operator goes to
//  ST_TOP, and each popped operator passes ST_TOP and then ST_NEXT. Ending the
//  expression flushes each operator the same way, then checks the stack once
//  more, and ST_RD re-reads the top after an operator's push. Each pop is a
//  registered stack RAM read, then the emit. Reset empties the stack (count
//  only, RAM is not cleared). A stalled output register holds the sequencer at
//  its emit step; the next beat is taken while the last result still waits.
//
module infix_to_postfix_converter_top
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] symbol
    input  wire logic       s_axis_tlast,   // expr_end
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic      [7:0] m_axis_tdata,   // [7:0] out_symbol
    output logic            m_axis_tlast,   // run_last
    output logic      [1:0] m_axis_tuser    // [0] expr_done, [1] overflow
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // Sequencer and item registers
    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           flush_reg, flush_next;
    logic           ovf_reg, ovf_next;
    op_code_t       top_code_reg, top_code_next;
    logic [7:0]     sym_reg;
    logic           last_reg;
    op_code_t       code_reg;

    // Output register
    logic           out_valid_reg;
    logic [7:0]     out_sym_reg;
    logic           out_last_reg;
    logic           out_done_reg;
    logic           out_ovf_reg;

    // Controls
    logic           accept;
    logic           out_free;
    logic           emit;
    logic [7:0]     emit_sym;
    logic           emit_last;
    logic           emit_done;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic           wr_en;
    op_code_t       rd_data;
    logic [CW-1:0]  cnt_m1;
    logic [CW-1:0]  cnt_m2;
    logic           top_valid;
    logic           pop_now;
    logic           more;

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign cnt_m1    = count_reg - CW'(1);
    assign cnt_m2    = count_reg - CW'(2);
    assign top_valid = (count_reg != '0);
    assign pop_now   = top_valid && (flush_reg || pops_before(rd_data, code_reg));

    // Remaining results after the pop in ST_NEXT (rd_data is the new top)
    always_comb
    begin
        if (flush_reg)
        begin
            more = (cnt_m1 != '0);
        end
        else
        begin
            more = last_reg || ((cnt_m1 != '0) && pops_before(rd_data, code_reg));
        end
    end

    // Operator stack memory
    itp_ram #(
        .WIDTH ($bits(op_code_t)),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (code_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = is_operator(s_axis_tdata) ? ST_TOP : ST_CHAR;
                end
            end
            ST_CHAR:
            begin
                if (out_free)
                begin
                    state_next = (last_reg && top_valid) ? ST_TOP : ST_IDLE;
                end
            end
            ST_TOP:
            begin
                if (pop_now)
                begin
                    state_next = ST_NEXT;
                end
                else if (!flush_reg && last_reg)
                begin
                    state_next = ST_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_NEXT:
            begin
                if (out_free)
                begin
                    state_next = ST_TOP;
                end
            end
            ST_RD:
            begin
                state_next = ST_TOP;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath controls
    always_comb
    begin
        s_axis_tready = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = cnt_m1[AW-1:0];
        wr_en         = 1'b0;
        emit          = 1'b0;
        emit_sym      = sym_reg;
        emit_last     = 1'b0;
        emit_done     = 1'b0;
        count_next    = count_reg;
        flush_next    = flush_reg;
        ovf_next      = ovf_reg;
        top_code_next = top_code_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (accept)
                begin
                    rd_en      = 1'b1;
                    flush_next = 1'b0;
                    ovf_next   = 1'b0;
                end
            end
            ST_CHAR:
            begin
                emit_last = !(last_reg && top_valid);
                emit_done = last_reg && !top_valid;
                if (out_free)
                begin
                    emit = 1'b1;
                    if (last_reg && top_valid)
                    begin
                        flush_next = 1'b1;
                    end
                end
            end
            ST_TOP:
            begin
                if (pop_now)
                begin
                    top_code_next = rd_data;
                    rd_en         = 1'b1;
                    rd_addr       = cnt_m2[AW-1:0];
                end
                else if (!flush_reg)
                begin
                    // push, or drop on a full stack
                    if (count_reg == CW'(STACK_DEPTH))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    if (last_reg)
                    begin
                        flush_next = 1'b1;
                    end
                end
            end
            ST_NEXT:
            begin
                emit_sym  = op_char(top_code_reg);
                emit_last = !more;
                emit_done = !more && last_reg;
                if (out_free)
                begin
                    emit       = 1'b1;
                    count_next = cnt_m1;
                end
            end
            ST_RD:
            begin
                rd_en = 1'b1;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            flush_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            flush_reg <= flush_next;
            ovf_reg   <= ovf_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        top_code_reg <= top_code_next;
        if (accept)
        begin
            sym_reg  <= s_axis_tdata;
            last_reg <= s_axis_tlast;
            code_reg <= op_encode(s_axis_tdata);
        end
        if (emit)
        begin
            out_sym_reg  <= emit_sym;
            out_last_reg <= emit_last;
            out_done_reg <= emit_done;
            out_ovf_reg  <= ovf_reg && (state_reg == ST_NEXT);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_sym_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = {out_ovf_reg, out_done_reg};

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count above depth");

    a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && emit_done) |=> (count_reg == '0))
        else $error("expression done with operators left on the stack");

    a_no_push_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !flush_reg)
        else $error("push during stack flush");

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("beat emitted over a waiting result");

endmodule
`default_nettype wire

/* rtl/itp_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// itp_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while rd_en is low.
// ============================================================================
module itp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

/* bench/infix_to_postfix_converter_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top_tb
// Stream-level check of the infix to postfix block. Expression characters
// are queued at time zero and played out by a clocked driver with random
// gaps. A clocked monitor with random back-pressure compares every output
// beat against a shunting-yard predictor that runs at input acceptance.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_top_tb;
    import itp_pkg::*;

    localparam int STACK_DEPTH  = STACK_DEPTH_DEF;
    localparam int N_DIRECTED   = 21;
    localparam int N_RANDOM     = 449;
    localparam int HOLD_AT      = 120;    // output beat count that starts the long hold
    localparam int HOLD_LEN     = 400;    // cycles of long receiver hold-off
    localparam int IDLE_LIMIT   = 3000;   // watchdog: cycles with no beat on either side
    localparam int TAIL_CYCLES  = 40;

    // One input character as queued for the driver
    typedef struct {
        logic [7:0] sym;
        logic       last;
        bit         no_gap;       // send with no idle cycles after it
        bit         drain_first;  // hold until every pending result is out
    } infix_beat_t;

    // One postfix output beat
    typedef struct packed {
        logic [7:0] sym;
        logic       run_last;
        logic       expr_done;
        logic       overflow;
    } postfix_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] symbol
    logic       s_axis_tlast = 1'b0;    // expr_end
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_symbol
    logic       m_axis_tlast;           // run_last
    logic [1:0] m_axis_tuser;           // [0] expr_done, [1] overflow

    infix_beat_t   infix_q [$];
    postfix_beat_t postfix_q [$];

    // Predictor state
    op_code_t   op_stack [STACK_DEPTH];
    int         op_depth = 0;
    int         peak_depth = 0;

    int         n_chars_in = 0;
    int         n_beats_out = 0;
    int         n_exprs = 0;
    int         n_errors = 0;
    int         n_holds = 0;
    int         n_drains = 0;

    // Generator flags
    bit         drain_next = 1'b0;
    bit         quiet_tx = 1'b0;

    infix_to_postfix_converter_top #(
        .STACK_DEPTH (STACK_DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Operator decode; returns 1 for + - * /
    function automatic bit decode_op(input logic [7:0] sym, output op_code_t code);
        bit hit;
        hit  = 1'b1;
        code = OP_ADD;
        case (sym)
            CH_PLUS:  code = OP_ADD;
            CH_MINUS: code = OP_SUB;
            CH_STAR:  code = OP_MUL;
            CH_SLASH: code = OP_DIV;
            default:  hit = 1'b0;
        endcase
        return hit;
    endfunction

    // * and / bind tighter than + and -
    function automatic int op_rank(input op_code_t code);
        return (code == OP_MUL || code == OP_DIV) ? 3 : 2;
    endfunction

    function automatic logic [7:0] code_to_char(input op_code_t code);
        logic [7:0] chars [4];
        chars = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
        return chars[code];
    endfunction

    // Shunting-yard step for one accepted character; queues its output beats
    task automatic convert_symbol(input logic [7:0] sym, input logic last);
        postfix_beat_t run [$];
        postfix_beat_t b;
        op_code_t      code;
        bit            ovf;
        int            k;

        ovf = 1'b0;
        b   = '0;
        if (!decode_op(sym, code)) begin
            b.sym = sym;
            run.push_back(b);
        end else begin
            // pop while top ranks at least as high as the new operator
            while (op_depth > 0 && op_rank(op_stack[op_depth-1]) >= op_rank(code)) begin
                op_depth--;
                b.sym = code_to_char(op_stack[op_depth]);
                run.push_back(b);
            end
            if (op_depth >= STACK_DEPTH) begin
                ovf = 1'b1;
            end else begin
                op_stack[op_depth] = code;
                op_depth++;
                if (op_depth > peak_depth)
                    peak_depth = op_depth;
            end
        end

        // end of expression: flush top first
        if (last) begin
            while (op_depth > 0) begin
                op_depth--;
                b.sym = code_to_char(op_stack[op_depth]);
                run.push_back(b);
            end
            n_exprs++;
        end

        for (k = 0; k < run.size(); k++) begin
            b           = run[k];
            b.overflow  = ovf;
            b.run_last  = (k == run.size() - 1);
            b.expr_done = last && (k == run.size() - 1);
            postfix_q.push_back(b);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        n_errors++;
    endtask

    task automatic queue_char(input logic [7:0] sym, input logic last);
        infix_beat_t it;
        it.sym         = sym;
        it.last        = last;
        it.no_gap      = quiet_tx;
        it.drain_first = drain_next;
        drain_next     = 1'b0;
        infix_q.push_back(it);
    endtask

    // Random operand: mostly letters, sometimes any non-operator byte
    function automatic logic [7:0] rand_operand();
        logic [7:0] c;
        op_code_t   dummy;
        if ($urandom_range(0, 3) != 0)
            return 8'(8'h61 + $urandom_range(0, 25));
        do
            c = 8'($urandom_range(0, 255));
        while (decode_op(c, dummy));
        return c;
    endfunction

    function automatic logic [7:0] rand_operator();
        logic [7:0] ops [4];
        ops = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
        return ops[$urandom_range(0, 3)];
    endfunction

    // Driver: plays infix_q out with random gaps, predicts at acceptance
    always @(posedge clk)
    begin : driver
        infix_beat_t cur;
        int          idle_left;
        int          cur_gap;
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                convert_symbol(cur.sym, cur.last);
                n_chars_in++;
                idle_left = cur_gap;
            end else if (!s_axis_tvalid && idle_left != 0) begin
                idle_left--;
            end

            if (s_axis_tvalid && !s_axis_tready) begin
                // beat held until taken
            end else if (idle_left == 0 && infix_q.size() != 0 &&
                         (!infix_q[0].drain_first || postfix_q.size() == 0)) begin
                cur = infix_q.pop_front();
                if (cur.drain_first)
                    n_drains++;
                cur_gap       = cur.no_gap ? 0 : $urandom_range(0, 9);
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= cur.sym;
                s_axis_tlast  <= cur.last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end else begin
            idle_left = 0;
            cur_gap   = 0;
        end
    end

    // Monitor: random back-pressure, one long hold-off, field-by-field check
    always @(posedge clk)
    begin : monitor
        postfix_beat_t got;
        postfix_beat_t want;
        int            stall_left;
        int            hold_left;
        bit            quiet_rx;
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata, m_axis_tlast, m_axis_tuser[0], m_axis_tuser[1]};
                if (postfix_q.size() == 0) begin
                    report_mismatch("unexpected beat", got.sym, 0);
                end else begin
                    want = postfix_q.pop_front();
                    if (got.sym !== want.sym)
                        report_mismatch("out_symbol", got.sym, want.sym);
                    if (got.run_last !== want.run_last)
                        report_mismatch("run_last", got.run_last, want.run_last);
                    if (got.expr_done !== want.expr_done)
                        report_mismatch("expr_done", got.expr_done, want.expr_done);
                    if (got.overflow !== want.overflow)
                        report_mismatch("overflow", got.overflow, want.overflow);
                end
                n_beats_out++;
                // a stretch of results taken with no stalls
                quiet_rx   = (n_beats_out >= 300 && n_beats_out < 380);
                stall_left = quiet_rx ? 0 : $urandom_range(0, 9);
                if (n_beats_out == HOLD_AT) begin
                    hold_left = HOLD_LEN;
                    n_holds++;
                end
            end else if (hold_left != 0) begin
                hold_left--;
            end else if (stall_left != 0) begin
                stall_left--;
            end
            m_axis_tready <= (hold_left == 0 && stall_left == 0);
        end else begin
            stall_left = 0;
            hold_left  = 0;
        end
    end

    // Watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin : watchdog
        int quiet_cycles;
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("[%0t] timeout: no beat for %0d cycles", $time, IDLE_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin : main
        int          roll;
        int          n;
        int          i;
        logic [7:0]  expr [$];

        // directed: byte extremes as lone operands
        queue_char(8'h00, 1'b0);
        queue_char(8'hFF, 1'b1);
        // mixed precedence chain: a+b*c-d/e
        expr = '{8'h61, CH_PLUS, 8'h62, CH_STAR, 8'h63, CH_MINUS, 8'h64, CH_SLASH, 8'h65};
        foreach (expr[k])
            queue_char(expr[k], k == expr.size() - 1);
        // lone operator that ends the expression
        queue_char(CH_STAR, 1'b1);
        // operator on an empty stack gives nothing, then equal and higher ranks
        queue_char(CH_PLUS, 1'b0);
        queue_char(CH_MINUS, 1'b0);
        queue_char(CH_STAR, 1'b0);
        queue_char(CH_SLASH, 1'b1);
        // high rank popped by a low one: a*b+c
        expr = '{8'h61, CH_STAR, 8'h62, CH_PLUS, 8'h63};
        foreach (expr[k])
            queue_char(expr[k], k == expr.size() - 1);

        // random part: mostly well-formed expressions, some noise and broken ones
        drain_next = 1'b1;
        while (infix_q.size() < N_DIRECTED + N_RANDOM) begin
            if (infix_q.size() >= 250 && infix_q.size() < 256)
                drain_next = 1'b1;
            quiet_tx = (infix_q.size() >= 350 && infix_q.size() < 420);
            roll = $urandom_range(0, 9);
            if (roll < 8) begin
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++) begin
                    queue_char(rand_operand(), i == n - 1);
                    if (i != n - 1)
                        queue_char(rand_operator(), 1'b0);
                end
            end else if (roll == 8) begin
                n = $urandom_range(1, 4);
                for (i = 0; i < n; i++)
                    queue_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end else begin
                // operator runs, ending on an operator
                n = $urandom_range(1, 5);
                for (i = 0; i < n; i++)
                    queue_char($urandom_range(0, 1) ? rand_operator() : rand_operand(),
                               1'b0);
                queue_char(rand_operator(), 1'b1);
            end
        end
        quiet_tx = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // wait for the stimulus to drain and every result to arrive
        while (!(infix_q.size() == 0 && !s_axis_tvalid && postfix_q.size() == 0))
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (postfix_q.size() != 0)
            report_mismatch("missing beats", postfix_q.size(), 0);

        $display("Sent %0d characters in %0d expressions, checked %0d postfix beats.",
                 n_chars_in, n_exprs, n_beats_out);
        $display("Peak stack depth %0d, %0d long output holds, %0d drain pauses, %0d errors.",
                 peak_depth, n_holds, n_drains, n_errors);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/itp_pkg.sv
rtl/itp_ram.sv
rtl/infix_to_postfix_converter_top.sv
bench/infix_to_postfix_converter_top_tb.sv
